// ----- hdl/dqso_pkg.sv -----
package dqso_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned GainW  = 32;
  localparam int unsigned LimitW = 16;
  localparam int unsigned DistW  = 64;
  localparam int unsigned MeanW  = 48;
  localparam int unsigned AddrW  = 4;

  localparam logic [LimitW-1:0] DistanceLimitReset = 16'd10000;

  typedef enum logic [1:0] {
    RegSpeedGain     = 2'd0,
    RegDistanceGain  = 2'd1,
    RegDistanceLimit = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]  speed_gain;
    logic [GainW-1:0]  distance_gain;
    logic [LimitW-1:0] distance_limit;
  } cfg_t;

  // one beat after decode and the multipliers
  typedef struct packed {
    logic              op;
    logic [CountW-1:0] count_left;
    logic [CountW-1:0] count_right;
    logic [CountW-1:0] delta_left;
    logic [CountW-1:0] delta_right;
    logic [DistW-1:0]  speed_prod_left;
    logic [DistW-1:0]  speed_prod_right;
    logic [DistW-1:0]  dist_prod_left;
    logic [DistW-1:0]  dist_prod_right;
  } stage_t;

endpackage

// ----- hdl/dual_quadrature_speed_odometer_core.sv -----
// Dual x4 quadrature decoder with speed and odometry.
// Input channel (in_valid_i/in_ready_o): one beat is either a pin edge event
// (op_i = 0, edge_mask_i names changed pins, pin_levels_i their levels) or a
// measurement tick (op_i = 1). Every beat gives exactly one result beat on
// the output channel (out_valid_o/out_ready_i) with running counts, tick
// deltas, saturated Q16.16 speeds, Q16.16 mean distance and the clear flag.
// An accepted beat passes the stage register and then the result
// register: decode and the gain multipliers sit before the stage register,
// distance update and limit test before the result register.
// Throughput: one beat per cycle while out_ready_i is high, set by the
// two-stage pipeline; the distance accumulators close their loop within
// the second stage.
// When the receiver stalls, the result register holds and the pipeline
// stops; in_ready_o stays high while the stage register is empty.
// Reset clears counts, snapshots, distances and gains; distance_limit
// reads 10000. Configuration sits on an APB port, registers at 4*i; the
// user must write it only while the block is idle, which it does not enforce.
module dual_quadrature_speed_odometer_core import dqso_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic [3:0]               edge_mask_i,
  input  logic [3:0]               pin_levels_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CountW-1:0] count_left_o,
  output logic signed [CountW-1:0] count_right_o,
  output logic signed [CountW-1:0] delta_left_o,
  output logic signed [CountW-1:0] delta_right_o,
  output logic signed [CountW-1:0] speed_left_o,
  output logic signed [CountW-1:0] speed_right_o,
  output logic signed [MeanW-1:0]  distance_mean_o,
  output logic                     distance_cleared_o
);

  cfg_t   cfg;
  stage_t stage;
  logic   stage_valid, advance;

  dqso_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dqso_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .edge_mask_i   (edge_mask_i),
    .pin_levels_i  (pin_levels_i),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .stage_o       (stage)
  );

  dqso_odometry u_odometry (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .stage_valid_i      (stage_valid),
    .stage_i            (stage),
    .advance_o          (advance),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .count_left_o       (count_left_o),
    .count_right_o      (count_right_o),
    .delta_left_o       (delta_left_o),
    .delta_right_o      (delta_right_o),
    .speed_left_o       (speed_left_o),
    .speed_right_o      (speed_right_o),
    .distance_mean_o    (distance_mean_o),
    .distance_cleared_o (distance_cleared_o)
  );

endmodule

// ----- hdl/dqso_cfg.sv -----
module dqso_cfg import dqso_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_gain     <= '0;
      cfg_q.distance_gain  <= '0;
      cfg_q.distance_limit <= DistanceLimitReset;
    end else if (wr) begin
      unique case (idx)
        RegSpeedGain:     cfg_q.speed_gain     <= pwdata;
        RegDistanceGain:  cfg_q.distance_gain  <= pwdata;
        RegDistanceLimit: cfg_q.distance_limit <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegSpeedGain:     prdata = cfg_q.speed_gain;
      RegDistanceGain:  prdata = cfg_q.distance_gain;
      RegDistanceLimit: prdata = {{(32-LimitW){1'b0}}, cfg_q.distance_limit};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- hdl/dqso_decode.sv -----
module dqso_decode import dqso_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [3:0] edge_mask_i,
  input  logic [3:0] pin_levels_i,
  input  logic       advance_i,
  output logic       stage_valid_o,
  output stage_t     stage_o
);

  logic [CountW-1:0] cnt_l_q, cnt_r_q, snap_l_q, snap_r_q;
  logic [CountW-1:0] cnt_l_d, cnt_r_d, dl, dr;
  logic [2:0]        step_l, step_r;
  logic              accept;
  logic              stage_valid_q;
  stage_t            stage_q;
  logic signed [32:0] dl_s, ndr_s, sg_s, dg_s;
  logic signed [65:0] sp_l, sp_r, dp_l, dp_r;

  function automatic logic [2:0] wheel_step(input logic [1:0] mask, input logic [1:0] lv);
    logic [2:0] s;
    s = '0;
    if (mask[0]) s = s + ((lv[0] != lv[1]) ? 3'd1 : 3'b111);
    if (mask[1]) s = s + ((lv[0] == lv[1]) ? 3'd1 : 3'b111);
    return s;
  endfunction

  assign in_ready_o    = advance_i || !stage_valid_q;
  assign accept        = in_valid_i && in_ready_o;
  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

  always_comb begin
    step_l  = wheel_step(edge_mask_i[1:0], pin_levels_i[1:0]);
    step_r  = wheel_step(edge_mask_i[3:2], pin_levels_i[3:2]);
    cnt_l_d = cnt_l_q + {{(CountW-3){step_l[2]}}, step_l};
    cnt_r_d = cnt_r_q + {{(CountW-3){step_r[2]}}, step_r};
    dl      = op_i ? (cnt_l_q - snap_l_q) : '0;
    dr      = op_i ? (cnt_r_q - snap_r_q) : '0;
    dl_s    = $signed({dl[CountW-1], dl});
    ndr_s   = -$signed({dr[CountW-1], dr});
    sg_s    = $signed({1'b0, cfg_i.speed_gain});
    dg_s    = $signed({1'b0, cfg_i.distance_gain});
    sp_l    = dl_s * sg_s;
    sp_r    = ndr_s * sg_s;
    dp_l    = dl_s * dg_s;
    dp_r    = ndr_s * dg_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_l_q       <= '0;
      cnt_r_q       <= '0;
      snap_l_q      <= '0;
      snap_r_q      <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) stage_valid_q <= accept;
      if (accept) begin
        if (op_i) begin
          snap_l_q <= cnt_l_q;
          snap_r_q <= cnt_r_q;
        end else begin
          cnt_l_q <= cnt_l_d;
          cnt_r_q <= cnt_r_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.op               <= op_i;
      stage_q.count_left       <= op_i ? cnt_l_q : cnt_l_d;
      stage_q.count_right      <= op_i ? cnt_r_q : cnt_r_d;
      stage_q.delta_left       <= dl;
      stage_q.delta_right      <= dr;
      stage_q.speed_prod_left  <= sp_l[DistW-1:0];
      stage_q.speed_prod_right <= sp_r[DistW-1:0];
      stage_q.dist_prod_left   <= dp_l[DistW-1:0];
      stage_q.dist_prod_right  <= dp_r[DistW-1:0];
    end
  end

  a_empty_mask_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !op_i && edge_mask_i == 4'd0 |=> $stable(cnt_l_q) && $stable(cnt_r_q))
    else $error("edge beat with empty mask moved a count");

  a_tick_snapshots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i |=> snap_l_q == cnt_l_q && snap_r_q == cnt_r_q)
    else $error("snapshot not taken on tick");

  a_edge_no_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !op_i |=> stage_q.delta_left == '0 && stage_q.delta_right == '0
      && stage_q.dist_prod_left == '0 && stage_q.dist_prod_right == '0)
    else $error("edge beat carries delta");

endmodule

// ----- hdl/dqso_odometry.sv -----
module dqso_odometry import dqso_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     stage_valid_i,
  input  stage_t                   stage_i,
  output logic                     advance_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [CountW-1:0] count_left_o,
  output logic signed [CountW-1:0] count_right_o,
  output logic signed [CountW-1:0] delta_left_o,
  output logic signed [CountW-1:0] delta_right_o,
  output logic signed [CountW-1:0] speed_left_o,
  output logic signed [CountW-1:0] speed_right_o,
  output logic signed [MeanW-1:0]  distance_mean_o,
  output logic                     distance_cleared_o
);

  logic [DistW-1:0]  dist_l_q, dist_r_q, lsum, rsum;
  logic [DistW:0]    sum, thr;
  logic              load, exceed, out_valid_q, op_q, cleared_q;
  logic [CountW-1:0] cnt_l_q, cnt_r_q, dl_q, dr_q, sl_q, sr_q;
  logic [MeanW-1:0]  mean_q;

  function automatic logic [CountW-1:0] sat_speed(input logic [DistW-1:0] p);
    logic [16:0] top;
    top = p[63:47];
    if (&top || ~|top) return p[47:16];
    return p[63] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  assign advance_o = !out_valid_q || out_ready_i;
  assign load      = advance_o && stage_valid_i;

  always_comb begin
    lsum   = dist_l_q + stage_i.dist_prod_left;
    rsum   = dist_r_q + stage_i.dist_prod_right;
    sum    = {lsum[DistW-1], lsum} + {rsum[DistW-1], rsum};
    thr    = {{(DistW+1-LimitW-33){1'b0}}, cfg_i.distance_limit, 33'd0};
    exceed = stage_i.op && ($signed(sum) > $signed(thr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_l_q    <= '0;
      dist_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance_o) out_valid_q <= stage_valid_i;
      if (load) begin
        dist_l_q <= exceed ? '0 : lsum;
        dist_r_q <= exceed ? '0 : rsum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q      <= stage_i.op;
      cnt_l_q   <= stage_i.count_left;
      cnt_r_q   <= stage_i.count_right;
      dl_q      <= stage_i.delta_left;
      dr_q      <= stage_i.delta_right;
      sl_q      <= sat_speed(stage_i.speed_prod_left);
      sr_q      <= sat_speed(stage_i.speed_prod_right);
      mean_q    <= exceed ? '0 : sum[DistW:DistW-MeanW+1];
      cleared_q <= exceed;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign count_left_o       = $signed(cnt_l_q);
  assign count_right_o      = $signed(cnt_r_q);
  assign delta_left_o       = $signed(dl_q);
  assign delta_right_o      = $signed(dr_q);
  assign speed_left_o       = $signed(sl_q);
  assign speed_right_o      = $signed(sr_q);
  assign distance_mean_o    = $signed(mean_q);
  assign distance_cleared_o = cleared_q;

  a_edge_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !op_q |-> dl_q == '0 && dr_q == '0 && sl_q == '0 && sr_q == '0
      && !cleared_q)
    else $error("edge result with tick fields set");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && exceed |=> dist_l_q == '0 && dist_r_q == '0)
    else $error("distances not cleared");

  a_clear_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && cleared_q |-> mean_q == '0)
    else $error("cleared beat with non-zero mean");

endmodule
